// ===== rtl/kbd_pkg.sv =====
package kbd_pkg;

   localparam int KEY_COUNT = 62;
   localparam int KEY_IDX_W = $clog2(KEY_COUNT);
   localparam int CAPS_KEY = 28;
   localparam int ADDR_W = 32;
   localparam int CODE_W = 8;

   localparam logic [ADDR_W-1:0] BASE_RESET = 32'hF100_2000;
   localparam logic [ADDR_W-1:0] DATA_OFFSET = 32'd4;
   localparam logic [ADDR_W-1:0] DIR_OFFSET = 32'd8;
   localparam logic [ADDR_W-1:0] FLAG_REARM = 32'd1;

   localparam logic [1:0] MODE_SCAN = 2'd0;
   localparam logic [1:0] MODE_READ = 2'd1;
   localparam logic [1:0] MODE_WRITE = 2'd2;

   typedef enum logic [1:0] {
      REG_NONE,
      REG_FLAG,
      REG_DATA,
      REG_DIR
   } reg_sel_type;

   localparam logic [CODE_W-1:0] LOWER_TABLE [KEY_COUNT] = '{
      8'd96, 8'd49, 8'd50, 8'd51, 8'd52, 8'd53, 8'd54, 8'd55, 8'd56, 8'd57, 8'd48, 8'd45,
      8'd61, 8'd8, 8'd9, 8'd113, 8'd119, 8'd101, 8'd114, 8'd116, 8'd121, 8'd117, 8'd105,
      8'd111, 8'd112, 8'd91, 8'd93, 8'd10, 8'd128, 8'd97, 8'd115, 8'd100, 8'd102, 8'd103,
      8'd104, 8'd106, 8'd107, 8'd108, 8'd59, 8'd39, 8'd35, 8'd129, 8'd92, 8'd122, 8'd120,
      8'd99, 8'd118, 8'd98, 8'd110, 8'd109, 8'd44, 8'd46, 8'd47, 8'd129, 8'd130, 8'd131,
      8'd132, 8'd32, 8'd133, 8'd134, 8'd135, 8'd130
   };

   localparam logic [CODE_W-1:0] UPPER_TABLE [KEY_COUNT] = '{
      8'd126, 8'd33, 8'd34, 8'd36, 8'd36, 8'd37, 8'd94, 8'd38, 8'd42, 8'd40, 8'd41, 8'd95,
      8'd43, 8'd8, 8'd9, 8'd81, 8'd87, 8'd69, 8'd82, 8'd84, 8'd89, 8'd85, 8'd73, 8'd79,
      8'd80, 8'd123, 8'd125, 8'd10, 8'd128, 8'd65, 8'd83, 8'd68, 8'd70, 8'd71, 8'd72,
      8'd74, 8'd75, 8'd76, 8'd58, 8'd64, 8'd126, 8'd129, 8'd124, 8'd90, 8'd88, 8'd67,
      8'd86, 8'd66, 8'd78, 8'd77, 8'd60, 8'd62, 8'd63, 8'd129, 8'd130, 8'd131, 8'd132,
      8'd32, 8'd133, 8'd134, 8'd135, 8'd130
   };

endpackage

// ===== rtl/kbd_if.sv =====
interface kbd_req_if import kbd_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [1:0]           mode;
   logic [KEY_COUNT-1:0] key_states;
   logic [ADDR_W-1:0]    bus_address;
   logic [ADDR_W-1:0]    write_value;

   modport source (output valid, output mode, output key_states, output bus_address,
                   output write_value, input ready);
   modport sink (input valid, input mode, input key_states, input bus_address,
                 input write_value, output ready);
endinterface

interface kbd_rsp_if import kbd_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              irq_request;
   logic [CODE_W-1:0] read_data;
   logic              handled;
   logic              abort_flag;

   modport source (output valid, output irq_request, output read_data, output handled,
                   output abort_flag, input ready);
   modport sink (input valid, input irq_request, input read_data, input handled,
                 input abort_flag, output ready);
endinterface

// ===== rtl/keyboard_register_device.sv =====
// Path: the input register, then the result register, between input and result transfer.
// Throughput: one item per cycle while the result is not stalled; a stalled result holds
// while one more item waits in the input register, and the single-pass compare, priority
// encode and table lookup set the rate.
// Reset: synchronous, active high; clears key vector, caps count, ready flags, codes and
// restores the flag register base address.
module keyboard_register_device import kbd_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               csr_write_enable,
   input logic [ADDR_W-1:0]  csr_write_data,
   kbd_req_if.sink           req_ch,
   kbd_rsp_if.source         rsp_ch
);

   logic                 s1_valid_ff, s1_valid_in;
   logic [1:0]           s1_mode_ff;
   logic [KEY_COUNT-1:0] s1_keys_ff;
   logic [ADDR_W-1:0]    s1_addr_ff;
   logic [ADDR_W-1:0]    s1_wval_ff;

   logic [ADDR_W-1:0]    base_ff, base_in;
   logic [KEY_COUNT-1:0] prev_keys_ff, prev_keys_in;
   logic                 not_yet_ff, not_yet_in;
   logic [1:0]           caps_ff, caps_in;
   logic                 code_rdy_ff, code_rdy_in;
   logic                 dir_rdy_ff, dir_rdy_in;
   logic [CODE_W-1:0]    latest_code_ff, latest_code_in;
   logic                 latest_dir_ff, latest_dir_in;
   logic [CODE_W-1:0]    held_code_ff, held_code_in;
   logic                 held_dir_ff, held_dir_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 irq_ff, irq_in;
   logic [CODE_W-1:0]    rdata_ff, rdata_in;
   logic                 hit_ff, hit_in;
   logic                 abort_ff, abort_in;

   logic                 advance;
   logic                 fire;
   logic                 take;
   logic [KEY_COUNT-1:0] diff;
   logic [KEY_IDX_W-1:0] top;
   reg_sel_type          reg_sel;

   assign advance = !rsp_valid_ff || rsp_ch.ready;
   assign fire = s1_valid_ff && advance;
   assign req_ch.ready = !s1_valid_ff || advance;
   assign take = req_ch.valid && req_ch.ready;
   assign s1_valid_in = take ? 1'b1 : (s1_valid_ff && !advance);
   assign rsp_valid_in = fire ? 1'b1 : (rsp_valid_ff && !rsp_ch.ready);
   assign base_in = csr_write_enable ? csr_write_data : base_ff;

   assign diff = s1_keys_ff ^ prev_keys_ff;

   always_comb begin
      top = '0;
      for (int i = 0; i < KEY_COUNT; i++) begin
         if (diff[i]) begin
            top = KEY_IDX_W'(i);
         end
      end
   end

   always_comb begin
      if (s1_addr_ff == base_ff) begin
         reg_sel = REG_FLAG;
      end else if (s1_addr_ff == base_ff + DATA_OFFSET) begin
         reg_sel = REG_DATA;
      end else if (s1_addr_ff == base_ff + DIR_OFFSET) begin
         reg_sel = REG_DIR;
      end else begin
         reg_sel = REG_NONE;
      end
   end

   always_comb begin
      prev_keys_in = prev_keys_ff;
      not_yet_in = not_yet_ff;
      caps_in = caps_ff;
      code_rdy_in = code_rdy_ff;
      dir_rdy_in = dir_rdy_ff;
      latest_code_in = latest_code_ff;
      latest_dir_in = latest_dir_ff;
      held_code_in = held_code_ff;
      held_dir_in = held_dir_ff;
      irq_in = 1'b0;
      rdata_in = '0;
      hit_in = 1'b0;
      abort_in = 1'b0;
      case (s1_mode_ff)
         MODE_SCAN: begin
            prev_keys_in = s1_keys_ff;
            if (diff != '0) begin
               irq_in = 1'b1;
               if (diff[CAPS_KEY]) begin
                  caps_in = caps_ff + 2'd1;
               end
               latest_code_in = caps_in[1] ? UPPER_TABLE[top] : LOWER_TABLE[top];
               latest_dir_in = s1_keys_ff[top];
               if (not_yet_ff) begin
                  code_rdy_in = 1'b1;
                  dir_rdy_in = 1'b1;
                  not_yet_in = 1'b0;
               end
            end
         end
         MODE_READ: begin
            case (reg_sel)
               REG_FLAG: begin
                  hit_in = 1'b1;
                  rdata_in = CODE_W'(code_rdy_ff);
               end
               REG_DATA: begin
                  hit_in = 1'b1;
                  if (code_rdy_ff) begin
                     held_code_in = latest_code_ff;
                     code_rdy_in = 1'b0;
                  end
                  rdata_in = held_code_in;
               end
               REG_DIR: begin
                  hit_in = 1'b1;
                  if (dir_rdy_ff) begin
                     held_dir_in = latest_dir_ff;
                     dir_rdy_in = 1'b0;
                  end
                  rdata_in = CODE_W'(held_dir_in);
               end
               default: begin
               end
            endcase
         end
         MODE_WRITE: begin
            case (reg_sel)
               REG_FLAG: begin
                  hit_in = 1'b1;
                  if (s1_wval_ff == FLAG_REARM) begin
                     code_rdy_in = 1'b1;
                     dir_rdy_in = 1'b1;
                  end
               end
               REG_DATA, REG_DIR: begin
                  hit_in = 1'b1;
                  abort_in = 1'b1;
               end
               default: begin
               end
            endcase
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         base_ff <= BASE_RESET;
         prev_keys_ff <= '0;
         not_yet_ff <= 1'b1;
         caps_ff <= '0;
         code_rdy_ff <= 1'b0;
         dir_rdy_ff <= 1'b0;
         latest_code_ff <= '0;
         latest_dir_ff <= 1'b0;
         held_code_ff <= '0;
         held_dir_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         base_ff <= base_in;
         if (fire) begin
            prev_keys_ff <= prev_keys_in;
            not_yet_ff <= not_yet_in;
            caps_ff <= caps_in;
            code_rdy_ff <= code_rdy_in;
            dir_rdy_ff <= dir_rdy_in;
            latest_code_ff <= latest_code_in;
            latest_dir_ff <= latest_dir_in;
            held_code_ff <= held_code_in;
            held_dir_ff <= held_dir_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s1_mode_ff <= req_ch.mode;
         s1_keys_ff <= req_ch.key_states;
         s1_addr_ff <= req_ch.bus_address;
         s1_wval_ff <= req_ch.write_value;
      end
      if (fire) begin
         irq_ff <= irq_in;
         rdata_ff <= rdata_in;
         hit_ff <= hit_in;
         abort_ff <= abort_in;
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.irq_request = irq_ff;
   assign rsp_ch.read_data = rdata_ff;
   assign rsp_ch.handled = hit_ff;
   assign rsp_ch.abort_flag = abort_ff;

endmodule
